### rtl/hrhp_pkg.sv
// hrhp_pkg: types, codes, character tables and byte classification
// for the http request header parser; no dependencies
package hrhp_pkg;

	localparam int OUT_W      = 48;
	localparam int LIMIT_W    = 16;
	localparam int QDEPTH     = 4;
	localparam int QPW        = 2;

	localparam logic [LIMIT_W-1:0] LIMIT_RESET = 16'd2048;

	localparam logic [3:0] CONN_LEN  = 4'd11;
	localparam logic [3:0] RANGE_LEN = 4'd6;
	localparam logic [3:0] UNIT_LEN  = 4'd6;
	localparam logic [3:0] CLOSE_LEN = 4'd5;

	localparam logic [7:0] CH_CR   = 8'h0D;
	localparam logic [7:0] CH_LF   = 8'h0A;
	localparam logic [7:0] CH_SP   = 8'h20;
	localparam logic [7:0] CH_DASH = 8'h2D;
	localparam logic [7:0] CH_ZERO = 8'h30;
	localparam logic [7:0] CH_NINE = 8'h39;

	localparam logic [2:0] M_NONE    = 3'd0;
	localparam logic [2:0] M_GET     = 3'd1;
	localparam logic [2:0] M_HEAD    = 3'd2;
	localparam logic [2:0] M_OPTIONS = 3'd3;
	localparam logic [2:0] M_PUT     = 3'd4;
	localparam logic [2:0] M_DELETE  = 3'd5;
	localparam logic [2:0] M_PATCH   = 3'd6;
	localparam logic [2:0] M_POST    = 3'd7;

	localparam logic [2:0] ST_OK        = 3'd0;
	localparam logic [2:0] ST_UNKNOWN   = 3'd1;
	localparam logic [2:0] ST_BARRED    = 3'd2;
	localparam logic [2:0] ST_BAD_RANGE = 3'd3;
	localparam logic [2:0] ST_TOO_LARGE = 3'd4;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       restart;
	} req_t;

	typedef struct packed {
		logic [2:0]       status;
		logic [2:0]       method;
		logic             close_after;
		logic [OUT_W-1:0] range_low;
		logic [OUT_W-1:0] range_high;
		logic             has_low;
		logic             has_high;
	} res_t;

	typedef struct packed {
		logic       digit;
		logic [3:0] dval;
		logic       cr;
		logic       lf;
		logic       space;
		logic       dash;
	} cls_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       restart;
		cls_t       cls;
	} qent_t;

	typedef struct packed {
		logic  valid;
		qent_t ent;
	} qpush_t;

	typedef struct packed {
		logic  valid;
		qent_t ent;
	} qhead_t;

	function automatic cls_t classify(input logic [7:0] c);
		cls_t r;
		logic [7:0] d;
		d       = c - CH_ZERO;
		r.digit = (c >= CH_ZERO) && (c <= CH_NINE);
		r.dval  = d[3:0];
		r.cr    = (c == CH_CR);
		r.lf    = (c == CH_LF);
		r.space = (c == CH_SP);
		r.dash  = (c == CH_DASH);
		return r;
	endfunction

	function automatic logic [3:0] meth_len(input logic [2:0] m);
		case (m)
			M_GET:     return 4'd3;
			M_HEAD:    return 4'd4;
			M_OPTIONS: return 4'd7;
			M_PUT:     return 4'd3;
			M_DELETE:  return 4'd6;
			M_PATCH:   return 4'd5;
			M_POST:    return 4'd4;
			default:   return 4'd0;
		endcase
	endfunction

	function automatic logic [7:0] meth_char(input logic [2:0] m, input logic [3:0] i);
		logic [7:0] r;
		r = 8'h00;
		case (m)
			M_GET: begin
				case (i)
					4'd0: r = "G"; 4'd1: r = "E"; 4'd2: r = "T";
					default: r = 8'h00;
				endcase
			end
			M_HEAD: begin
				case (i)
					4'd0: r = "H"; 4'd1: r = "E"; 4'd2: r = "A"; 4'd3: r = "D";
					default: r = 8'h00;
				endcase
			end
			M_OPTIONS: begin
				case (i)
					4'd0: r = "O"; 4'd1: r = "P"; 4'd2: r = "T"; 4'd3: r = "I";
					4'd4: r = "O"; 4'd5: r = "N"; 4'd6: r = "S";
					default: r = 8'h00;
				endcase
			end
			M_PUT: begin
				case (i)
					4'd0: r = "P"; 4'd1: r = "U"; 4'd2: r = "T";
					default: r = 8'h00;
				endcase
			end
			M_DELETE: begin
				case (i)
					4'd0: r = "D"; 4'd1: r = "E"; 4'd2: r = "L"; 4'd3: r = "E";
					4'd4: r = "T"; 4'd5: r = "E";
					default: r = 8'h00;
				endcase
			end
			M_PATCH: begin
				case (i)
					4'd0: r = "P"; 4'd1: r = "A"; 4'd2: r = "T"; 4'd3: r = "C";
					4'd4: r = "H";
					default: r = 8'h00;
				endcase
			end
			M_POST: begin
				case (i)
					4'd0: r = "P"; 4'd1: r = "O"; 4'd2: r = "S"; 4'd3: r = "T";
					default: r = 8'h00;
				endcase
			end
			default: r = 8'h00;
		endcase
		return r;
	endfunction

	function automatic logic [7:0] conn_char(input logic [3:0] i);
		case (i)
			4'd0:    return "C";
			4'd1:    return "o";
			4'd2:    return "n";
			4'd3:    return "n";
			4'd4:    return "e";
			4'd5:    return "c";
			4'd6:    return "t";
			4'd7:    return "i";
			4'd8:    return "o";
			4'd9:    return "n";
			4'd10:   return ":";
			default: return 8'h00;
		endcase
	endfunction

	function automatic logic [7:0] range_char(input logic [3:0] i);
		case (i)
			4'd0:    return "R";
			4'd1:    return "a";
			4'd2:    return "n";
			4'd3:    return "g";
			4'd4:    return "e";
			4'd5:    return ":";
			default: return 8'h00;
		endcase
	endfunction

	function automatic logic [7:0] unit_char(input logic [3:0] i);
		case (i)
			4'd0:    return "b";
			4'd1:    return "y";
			4'd2:    return "t";
			4'd3:    return "e";
			4'd4:    return "s";
			4'd5:    return "=";
			default: return 8'h00;
		endcase
	endfunction

	function automatic logic [7:0] close_char(input logic [3:0] i);
		case (i)
			4'd0:    return "c";
			4'd1:    return "l";
			4'd2:    return "o";
			4'd3:    return "s";
			4'd4:    return "e";
			default: return 8'h00;
		endcase
	endfunction

endpackage

### rtl/hrhp_stream_if.sv
// hrhp_stream_if: valid/ready channel carrying one payload of type T
// no dependencies; payload types come from hrhp_pkg at instantiation
interface hrhp_stream_if #(parameter type T = logic) ();
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

### rtl/hrhp_front.sv
// hrhp_front: accepts request bytes and tags each with its character class
// depends on hrhp_pkg and hrhp_stream_if
module hrhp_front
	import hrhp_pkg::*;
(
	hrhp_stream_if.sink req,
	input  logic        q_full,
	output qpush_t      push
);

	assign req.ready           = !q_full;
	assign push.valid          = req.valid && !q_full;
	assign push.ent.data_byte  = req.data.data_byte;
	assign push.ent.restart    = req.data.restart;
	assign push.ent.cls        = classify(req.data.data_byte);

endmodule

### rtl/hrhp_queue.sv
// hrhp_queue: short fifo of classified bytes between front and back
// depends on hrhp_pkg
module hrhp_queue
	import hrhp_pkg::*;
(
	input  logic   clk,
	input  logic   arst_n,
	input  qpush_t push,
	input  logic   pop,
	output logic   full,
	output qhead_t head
);

	qent_t          mem_q [QDEPTH];
	logic [QPW-1:0] wr_ptr_q;
	logic [QPW-1:0] rd_ptr_q;
	logic [QPW:0]   cnt_q;

	logic do_push;
	logic do_pop;

	assign full       = (cnt_q == (QPW+1)'(QDEPTH));
	assign head.valid = (cnt_q != '0);
	assign head.ent   = mem_q[rd_ptr_q];
	assign do_push    = push.valid && !full;
	assign do_pop     = pop && head.valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push.ent;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({do_push, do_pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

### rtl/hrhp_back.sv
// hrhp_back: header parse state machine, one byte per cycle while no result is waiting, and result register
// depends on hrhp_pkg and hrhp_stream_if
module hrhp_back
	import hrhp_pkg::*;
#(
	parameter int VALUE_WIDTH = 48,
	parameter int COUNT_WIDTH = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  qhead_t             head,
	output logic               pop,
	input  logic [LIMIT_W-1:0] limit,
	hrhp_stream_if.source      rsp
);

	localparam int VW = VALUE_WIDTH;
	localparam int CW = COUNT_WIDTH;
	localparam int EW = ((CW > LIMIT_W) ? CW : LIMIT_W) + 1;

	localparam logic [3:0] PH_METH_FIRST = 4'd0;
	localparam logic [3:0] PH_METH_P     = 4'd1;
	localparam logic [3:0] PH_METH_REST  = 4'd2;
	localparam logic [3:0] PH_SKIP       = 4'd3;
	localparam logic [3:0] PH_LINE       = 4'd4;
	localparam logic [3:0] PH_CONN_NAME  = 4'd5;
	localparam logic [3:0] PH_RANGE_NAME = 4'd6;
	localparam logic [3:0] PH_CONN_WS    = 4'd7;
	localparam logic [3:0] PH_CONN_VAL   = 4'd8;
	localparam logic [3:0] PH_RANGE_WS   = 4'd9;
	localparam logic [3:0] PH_RANGE_UNIT = 4'd10;
	localparam logic [3:0] PH_RANGE_LOW  = 4'd11;
	localparam logic [3:0] PH_RANGE_HIGH = 4'd12;
	localparam logic [3:0] PH_FROZEN     = 4'd13;

	function automatic logic [VW-1:0] sat_digit(input logic [VW-1:0] v, input logic [3:0] d);
		logic [VW+3:0] w;
		w = ({4'b0, v} << 3) + ({4'b0, v} << 1) + (VW+4)'(d);
		if (w[VW+3:VW] != 4'b0) begin
			return '1;
		end
		return w[VW-1:0];
	endfunction

	logic [3:0]    phase_q;
	logic [3:0]    mprog_q;
	logic [2:0]    meth_q;
	logic          close_q;
	logic [VW-1:0] low_q;
	logic [VW-1:0] high_q;
	logic [2:0]    rflags_q;
	logic [CW-1:0] bcount_q;
	logic [1:0]    eom_q;
	logic          rsp_valid_q;
	res_t          res_q;

	logic [3:0]    ph_n;
	logic [3:0]    mp_n;
	logic [2:0]    mc_n;
	logic          cf_n;
	logic [VW-1:0] lo_n;
	logic [VW-1:0] hi_n;
	logic [2:0]    rf_n;
	logic [CW-1:0] bc_n;
	logic [1:0]    em_n;
	logic          emit;
	res_t          res_n;
	logic          adv;

	assign adv       = head.valid && (!rsp_valid_q || rsp.ready);
	assign pop       = adv;
	assign rsp.valid = rsp_valid_q;
	assign rsp.data  = res_q;

	always_comb begin
		logic [7:0] c;
		cls_t       cl;
		logic       done_eom;
		logic       done_lim;
		logic [2:0] m;
		c        = head.ent.data_byte;
		cl       = head.ent.cls;
		done_eom = 1'b0;
		done_lim = 1'b0;
		if (head.ent.restart) begin
			ph_n = PH_METH_FIRST;
			mp_n = '0;
			mc_n = M_NONE;
			cf_n = 1'b0;
			lo_n = '0;
			hi_n = '1;
			rf_n = '0;
			bc_n = '0;
			em_n = '0;
		end else begin
			ph_n = phase_q;
			mp_n = mprog_q;
			mc_n = meth_q;
			cf_n = close_q;
			lo_n = low_q;
			hi_n = high_q;
			rf_n = rflags_q;
			bc_n = bcount_q;
			em_n = eom_q;
		end

		case (ph_n)
			PH_METH_FIRST: begin
				mp_n = 4'd1;
				ph_n = PH_METH_REST;
				case (c)
					"G":     mc_n = M_GET;
					"H":     mc_n = M_HEAD;
					"O":     mc_n = M_OPTIONS;
					"D":     mc_n = M_DELETE;
					"P": begin
						mp_n = '0;
						ph_n = PH_METH_P;
					end
					default: begin
						mp_n = '0;
						mc_n = M_NONE;
						ph_n = PH_SKIP;
					end
				endcase
			end
			PH_METH_P: begin
				mp_n = 4'd2;
				ph_n = PH_METH_REST;
				case (c)
					"U":     mc_n = M_PUT;
					"A":     mc_n = M_PATCH;
					"O":     mc_n = M_POST;
					default: begin
						mp_n = mprog_q & {4{!head.ent.restart}};
						mc_n = M_NONE;
						ph_n = PH_SKIP;
					end
				endcase
			end
			PH_METH_REST: begin
				if (mp_n < meth_len(mc_n) && c == meth_char(mc_n, mp_n)) begin
					mp_n = mp_n + 4'd1;
					if (mp_n == meth_len(mc_n)) begin
						ph_n = PH_SKIP;
					end
				end else begin
					mc_n = M_NONE;
					ph_n = PH_SKIP;
				end
			end
			PH_LINE: begin
				mp_n = 4'd1;
				if (c == "C") begin
					ph_n = PH_CONN_NAME;
				end else if (c == "R") begin
					ph_n = PH_RANGE_NAME;
				end else begin
					ph_n = PH_SKIP;
				end
			end
			PH_CONN_NAME: begin
				if (mp_n < CONN_LEN && c == conn_char(mp_n)) begin
					mp_n = mp_n + 4'd1;
					if (mp_n == CONN_LEN) begin
						cf_n = 1'b0;
						ph_n = PH_CONN_WS;
					end
				end else begin
					ph_n = PH_SKIP;
				end
			end
			PH_RANGE_NAME: begin
				if (mp_n < RANGE_LEN && c == range_char(mp_n)) begin
					mp_n = mp_n + 4'd1;
					if (mp_n == RANGE_LEN) begin
						ph_n = PH_RANGE_WS;
					end
				end else begin
					ph_n = PH_SKIP;
				end
			end
			PH_CONN_WS: begin
				if (!cl.space) begin
					if (c == close_char(4'd0)) begin
						mp_n = 4'd1;
						ph_n = PH_CONN_VAL;
					end else begin
						mp_n = '0;
						ph_n = PH_SKIP;
					end
				end
			end
			PH_CONN_VAL: begin
				if (mp_n < CLOSE_LEN && c == close_char(mp_n)) begin
					mp_n = mp_n + 4'd1;
					if (mp_n == CLOSE_LEN) begin
						cf_n = 1'b1;
						ph_n = PH_SKIP;
					end
				end else begin
					ph_n = PH_SKIP;
				end
			end
			PH_RANGE_WS: begin
				if (!cl.space) begin
					if (c == unit_char(4'd0)) begin
						mp_n = 4'd1;
						ph_n = PH_RANGE_UNIT;
					end else begin
						mp_n = '0;
						ph_n = PH_SKIP;
					end
				end
			end
			PH_RANGE_UNIT: begin
				if (mp_n < UNIT_LEN && c == unit_char(mp_n)) begin
					mp_n = mp_n + 4'd1;
					if (mp_n == UNIT_LEN) begin
						lo_n      = '0;
						hi_n      = '1;
						rf_n[1:0] = 2'b00;
						ph_n      = PH_RANGE_LOW;
					end
				end else begin
					ph_n = PH_SKIP;
				end
			end
			PH_RANGE_LOW: begin
				if (cl.digit) begin
					lo_n    = sat_digit(lo_n, cl.dval);
					rf_n[0] = 1'b1;
				end else if (cl.dash) begin
					ph_n = PH_RANGE_HIGH;
				end else begin
					rf_n[2] = 1'b1;
					ph_n    = PH_FROZEN;
				end
			end
			PH_RANGE_HIGH: begin
				if (cl.digit) begin
					hi_n    = sat_digit(rf_n[1] ? hi_n : '0, cl.dval);
					rf_n[1] = 1'b1;
				end else begin
					ph_n = PH_SKIP;
				end
			end
			default: begin
			end
		endcase

		// end of header detection
		if (cl.cr) begin
			em_n = (em_n == 2'd2) ? 2'd3 : 2'd1;
		end else if (cl.lf) begin
			if (em_n == 2'd1) begin
				em_n = 2'd2;
			end else if (em_n == 2'd3) begin
				done_eom = 1'b1;
			end else begin
				em_n = 2'd0;
			end
		end else begin
			em_n = 2'd0;
		end

		if (!done_eom) begin
			if (em_n == 2'd2 && ph_n != PH_FROZEN) begin
				ph_n = PH_LINE;
				mp_n = '0;
			end
			if (bc_n != '1) begin
				bc_n = bc_n + CW'(1);
			end
			done_lim = (EW'(bc_n) >= EW'(limit)) || (bc_n == '1);
		end

		emit = done_eom || done_lim;
		m    = (ph_n <= PH_METH_REST) ? M_NONE : mc_n;

		if (done_lim) begin
			res_n.status = ST_TOO_LARGE;
		end else if (m == M_NONE) begin
			res_n.status = ST_UNKNOWN;
		end else if (m >= M_PUT) begin
			res_n.status = ST_BARRED;
		end else if (rf_n[2]) begin
			res_n.status = ST_BAD_RANGE;
		end else begin
			res_n.status = ST_OK;
		end
		res_n.method      = m;
		res_n.close_after = cf_n;
		res_n.range_low   = OUT_W'(lo_n);
		res_n.range_high  = OUT_W'(hi_n);
		res_n.has_low     = rf_n[0];
		res_n.has_high    = rf_n[1];
	end

	always_ff @(posedge clk) begin
		if (adv && emit) begin
			res_q <= res_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_METH_FIRST;
			mprog_q     <= '0;
			meth_q      <= M_NONE;
			close_q     <= 1'b0;
			low_q       <= '0;
			high_q      <= '1;
			rflags_q    <= '0;
			bcount_q    <= '0;
			eom_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (adv) begin
				rsp_valid_q <= emit;
				if (emit) begin
					phase_q  <= PH_METH_FIRST;
					mprog_q  <= '0;
					meth_q   <= M_NONE;
					close_q  <= 1'b0;
					low_q    <= '0;
					high_q   <= '1;
					rflags_q <= '0;
					bcount_q <= '0;
					eom_q    <= '0;
				end else begin
					phase_q  <= ph_n;
					mprog_q  <= mp_n;
					meth_q   <= mc_n;
					close_q  <= cf_n;
					low_q    <= lo_n;
					high_q   <= hi_n;
					rflags_q <= rf_n;
					bcount_q <= bc_n;
					eom_q    <= em_n;
				end
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

endmodule

### rtl/http_request_header_parser.sv
// http_request_header_parser: the request's last byte is written into the queue, then a parse step
// in hrhp_back loads the result register
// one byte per cycle sustained, set by the parse step in hrhp_back; the back holds
// while a result waits and the 4-entry queue keeps the front accepting for up to 4 bytes
// asynchronous active-low reset clears parse state, queue, result valid, limit to 2048
// depends on hrhp_pkg, hrhp_stream_if, hrhp_front, hrhp_queue, hrhp_back
module http_request_header_parser
	import hrhp_pkg::*;
#(
	parameter int VALUE_WIDTH = 48,
	parameter int COUNT_WIDTH = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [LIMIT_W-1:0] cfg_wdata,
	hrhp_stream_if.sink        req,
	hrhp_stream_if.source      rsp
);

	localparam logic [OUT_W-1:0] HI_OPEN = OUT_W'({VALUE_WIDTH{1'b1}});

	logic [LIMIT_W-1:0] max_header_bytes_q;
	qpush_t             push;
	qhead_t             head;
	logic               q_full;
	logic               pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_header_bytes_q <= LIMIT_RESET;
		end else if (cfg_we) begin
			max_header_bytes_q <= cfg_wdata;
		end
	end

	hrhp_front u_front (
		.req    (req),
		.q_full (q_full),
		.push   (push)
	);

	hrhp_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.pop    (pop),
		.full   (q_full),
		.head   (head)
	);

	hrhp_back #(
		.VALUE_WIDTH (VALUE_WIDTH),
		.COUNT_WIDTH (COUNT_WIDTH)
	) u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.head   (head),
		.pop    (pop),
		.limit  (max_header_bytes_q),
		.rsp    (rsp)
	);

`ifndef SYNTHESIS
	a_ok_method: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.data.status == ST_OK |->
			(rsp.data.method == M_GET || rsp.data.method == M_HEAD ||
			 rsp.data.method == M_OPTIONS))
		else $error("ok status with a method that is not allowed");

	a_unknown_method: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.data.status == ST_UNKNOWN |-> rsp.data.method == M_NONE)
		else $error("unknown status with a method code");

	a_open_high: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && !rsp.data.has_high |-> rsp.data.range_high == HI_OPEN)
		else $error("range high changed without high digits");

	a_queue_gate: assert property (@(posedge clk) disable iff (!arst_n)
		q_full |-> !req.ready && !push.valid)
		else $error("transaction accepted into a full queue");
`endif

endmodule
